### hdl/two_way_light_queue_server_core_macros.svh
// Assertion helpers used by the queue server engine RTL
`ifndef TWO_WAY_LIGHT_QUEUE_SERVER_CORE_MACROS_SVH
`define TWO_WAY_LIGHT_QUEUE_SERVER_CORE_MACROS_SVH

`ifndef SYNTH
`define TLQ_ASSERT_IMPL(label, clk, rst_n, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
`define TLQ_ASSERT_NEXT(label, clk, rst_n, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define TLQ_ASSERT_IMPL(label, clk, rst_n, ant, cons, msg)
`define TLQ_ASSERT_NEXT(label, clk, rst_n, ant, cons, msg)
`endif

`endif

### hdl/tlq_pkg.sv
`timescale 1ns / 1ps
package tlq_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PHASE_W     = 10;
    localparam int TIME_W      = 16;
    localparam int TOTAL_W     = 32;

    localparam logic [PHASE_W-1:0] GREEN_RESET = PHASE_W'(10);
    localparam logic [TIME_W-1:0]  MAX16       = '1;
    localparam logic [TOTAL_W-1:0] MAX32       = '1;

    typedef enum logic [0:0] {
        CFG_LEFT_GREEN  = 1'b0,
        CFG_RIGHT_GREEN = 1'b1
    } cfg_addr_t;

    typedef enum logic [1:0] {
        SERVED_NONE  = 2'd0,
        SERVED_LEFT  = 2'd1,
        SERVED_RIGHT = 2'd2
    } serve_t;

    typedef struct packed {
        logic left_arrival;
        logic right_arrival;
        logic drain_phase;
    } in_item_t;

    typedef struct packed {
        logic arrive_left;
        logic arrive_right;
        logic drain;
    } cmd_t;

    typedef struct packed {
        logic               light_side;
        serve_t             served_side;
        logic [TIME_W-1:0]  served_wait;
        logic [TIME_W-1:0]  left_vehicles;
        logic [TIME_W-1:0]  right_vehicles;
        logic [TOTAL_W-1:0] left_wait_total;
        logic [TOTAL_W-1:0] right_wait_total;
        logic [TIME_W-1:0]  left_max_wait;
        logic [TIME_W-1:0]  right_max_wait;
        logic [TIME_W-1:0]  left_clearance;
        logic [TIME_W-1:0]  right_clearance;
        logic               queues_empty;
    } result_t;

endpackage

### hdl/tlq_front.sv
`timescale 1ns / 1ps
module tlq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tlq_pkg::in_item_t item,
    output logic              cmd_valid,
    output tlq_pkg::cmd_t     cmd,
    input  logic              cmd_take
);

    tlq_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_take;
    tlq_pkg::cmd_t decoded;

    // drop arrivals once the drain phase has begun
    always_comb
    begin
        decoded.arrive_left  = item.left_arrival & ~item.drain_phase;
        decoded.arrive_right = item.right_arrival & ~item.drain_phase;
        decoded.drain        = item.drain_phase;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_take   = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_take;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### hdl/tlq_engine.sv
`timescale 1ns / 1ps
`include "two_way_light_queue_server_core_macros.svh"
module tlq_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  tlq_pkg::cfg_addr_t            cfg_addr,
    input  logic [tlq_pkg::PHASE_W-1:0]   cfg_data,
    input  logic                          cmd_valid,
    input  tlq_pkg::cmd_t                 cmd,
    output logic                          cmd_take,
    input  logic                          res_full,
    output logic                          res_push,
    output tlq_pkg::result_t              res
);

    localparam int PW = tlq_pkg::PTR_W;
    localparam int CW = tlq_pkg::CNT_W;
    localparam int HW = tlq_pkg::PHASE_W;
    localparam int TW = tlq_pkg::TIME_W;
    localparam int SW = tlq_pkg::TOTAL_W;
    localparam logic [CW-1:0] DEPTH_CNT = CW'(tlq_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR  = PW'(tlq_pkg::QUEUE_DEPTH - 1);

    logic [HW-1:0] left_green_reg, left_green_next;
    logic [HW-1:0] right_green_reg, right_green_next;
    logic [HW-1:0] left_phase_reg, left_phase_next;
    logic [HW-1:0] right_phase_reg, right_phase_next;
    logic          green_reg, green_next;
    logic [TW-1:0] period_reg, period_next;

    logic [PW-1:0] head_reg [2];
    logic [PW-1:0] head_next [2];
    logic [PW-1:0] tail_reg [2];
    logic [PW-1:0] tail_next [2];
    logic [CW-1:0] count_reg [2];
    logic [CW-1:0] count_next [2];
    logic [TW-1:0] vehicles_reg [2];
    logic [TW-1:0] vehicles_next [2];
    logic [SW-1:0] wait_total_reg [2];
    logic [SW-1:0] wait_total_next [2];
    logic [TW-1:0] max_wait_reg [2];
    logic [TW-1:0] max_wait_next [2];
    logic [TW-1:0] clearance_reg [2];
    logic [TW-1:0] clearance_next [2];

    logic [TW-1:0] left_times_mem [tlq_pkg::QUEUE_DEPTH];
    logic [TW-1:0] right_times_mem [tlq_pkg::QUEUE_DEPTH];
    logic [TW-1:0] rd_data_reg [2];
    logic [TW-1:0] bypass_data_reg [2];
    logic          bypass_sel_reg [2];

    logic          fire, idle, step;
    logic          switch_left, switch_right, green_mid, green_new;
    logic [HW-1:0] right_phase_mid, left_phase_mid;
    logic [1:0]    bumps;
    logic [TW+1:0] stamp_sum;
    logic [TW:0]   final_sum;
    logic [TW-1:0] stamp;
    logic          arrive [2];
    logic          push_ok [2];
    logic          wr_en [2];
    logic          pop [2];
    logic [CW-1:0] count_pushed [2];
    logic [TW-1:0] head_time [2];
    logic [TW-1:0] arrived;
    logic [TW-1:0] wait_val;
    logic [SW:0]   total_sum [2];
    logic          serve;
    logic          sel;

    assign fire     = cmd_valid && !res_full;
    assign cmd_take = fire;
    assign res_push = fire;
    assign idle     = cmd.drain && (count_reg[0] == '0) && (count_reg[1] == '0);
    assign step     = fire && !idle;

    // light change: left side first, then right
    always_comb
    begin
        switch_left     = !green_reg && (left_phase_reg == left_green_reg);
        green_mid       = green_reg | switch_left;
        right_phase_mid = switch_left ? '0 : right_phase_reg;
        switch_right    = green_mid && (right_phase_mid == right_green_reg);
        green_new       = green_mid & ~switch_right;
        left_phase_mid  = switch_right ? '0 : left_phase_reg;
        bumps           = {1'b0, switch_left} + {1'b0, switch_right};
        stamp_sum       = {2'b00, period_reg} + {{TW{1'b0}}, bumps};
        stamp           = (stamp_sum > {2'b00, tlq_pkg::MAX16}) ? tlq_pkg::MAX16
                                                                : stamp_sum[TW-1:0];
        final_sum       = {1'b0, stamp} + {{TW{1'b0}}, 1'b1};
        sel             = green_new;
    end

    always_comb
    begin
        arrive[0] = cmd.arrive_left;
        arrive[1] = cmd.arrive_right;
        for (int s = 0; s < 2; s++)
        begin
            push_ok[s]      = arrive[s] && (count_reg[s] != DEPTH_CNT);
            wr_en[s]        = step && push_ok[s];
            count_pushed[s] = count_reg[s] + {{(CW-1){1'b0}}, push_ok[s]};
            head_time[s]    = bypass_sel_reg[s] ? bypass_data_reg[s] : rd_data_reg[s];
        end
        serve = count_pushed[sel] != '0;
        // a car pushed into an empty queue is served in the same period
        arrived  = (count_reg[sel] == '0) ? stamp : head_time[sel];
        wait_val = serve ? (stamp - arrived) : '0;
        pop[0]   = serve && !sel;
        pop[1]   = serve && sel;
    end

    always_comb
    begin
        left_green_next  = left_green_reg;
        right_green_next = right_green_reg;
        if (cfg_write)
        begin
            unique case (cfg_addr)
                tlq_pkg::CFG_LEFT_GREEN:  left_green_next  = cfg_data;
                tlq_pkg::CFG_RIGHT_GREEN: right_green_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        green_next       = green_reg;
        left_phase_next  = left_phase_reg;
        right_phase_next = right_phase_reg;
        period_next      = period_reg;
        if (step)
        begin
            green_next       = green_new;
            left_phase_next  = green_new ? left_phase_mid : left_phase_mid + HW'(1);
            right_phase_next = green_new ? right_phase_mid + HW'(1) : right_phase_mid;
            period_next      = final_sum[TW] ? tlq_pkg::MAX16 : final_sum[TW-1:0];
        end
    end

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            head_next[s]       = head_reg[s];
            tail_next[s]       = tail_reg[s];
            count_next[s]      = count_reg[s];
            vehicles_next[s]   = vehicles_reg[s];
            wait_total_next[s] = wait_total_reg[s];
            max_wait_next[s]   = max_wait_reg[s];
            clearance_next[s]  = clearance_reg[s];
            total_sum[s]       = {1'b0, wait_total_reg[s]} + {{(SW-TW+1){1'b0}}, wait_val};
            if (step)
            begin
                if (push_ok[s])
                begin
                    tail_next[s] = (tail_reg[s] == LAST_PTR) ? '0 : tail_reg[s] + PW'(1);
                    if (vehicles_reg[s] != tlq_pkg::MAX16)
                    begin
                        vehicles_next[s] = vehicles_reg[s] + TW'(1);
                    end
                end
                if (pop[s])
                begin
                    head_next[s]       = (head_reg[s] == LAST_PTR) ? '0
                                                                   : head_reg[s] + PW'(1);
                    count_next[s]      = count_pushed[s] - CW'(1);
                    wait_total_next[s] = total_sum[s][SW] ? tlq_pkg::MAX32
                                                          : total_sum[s][SW-1:0];
                    if (wait_val > max_wait_reg[s])
                    begin
                        max_wait_next[s] = wait_val;
                    end
                end
                else
                begin
                    count_next[s] = count_pushed[s];
                    if ((sel == s[0]) && cmd.drain && (clearance_reg[s] == '0))
                    begin
                        clearance_next[s] = stamp;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.light_side       = green_next;
        res.served_side      = !(step && serve) ? tlq_pkg::SERVED_NONE :
                               (sel ? tlq_pkg::SERVED_RIGHT : tlq_pkg::SERVED_LEFT);
        res.served_wait      = step ? wait_val : '0;
        res.left_vehicles    = vehicles_next[0];
        res.right_vehicles   = vehicles_next[1];
        res.left_wait_total  = wait_total_next[0];
        res.right_wait_total = wait_total_next[1];
        res.left_max_wait    = max_wait_next[0];
        res.right_max_wait   = max_wait_next[1];
        res.left_clearance   = clearance_next[0];
        res.right_clearance  = clearance_next[1];
        res.queues_empty     = (count_next[0] == '0) && (count_next[1] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_green_reg  <= tlq_pkg::GREEN_RESET;
            right_green_reg <= tlq_pkg::GREEN_RESET;
            left_phase_reg  <= '0;
            right_phase_reg <= '0;
            green_reg       <= 1'b0;
            period_reg      <= '0;
            for (int s = 0; s < 2; s++)
            begin
                head_reg[s]       <= '0;
                tail_reg[s]       <= '0;
                count_reg[s]      <= '0;
                vehicles_reg[s]   <= '0;
                wait_total_reg[s] <= '0;
                max_wait_reg[s]   <= '0;
                clearance_reg[s]  <= '0;
            end
        end
        else
        begin
            left_green_reg  <= left_green_next;
            right_green_reg <= right_green_next;
            left_phase_reg  <= left_phase_next;
            right_phase_reg <= right_phase_next;
            green_reg       <= green_next;
            period_reg      <= period_next;
            for (int s = 0; s < 2; s++)
            begin
                head_reg[s]       <= head_next[s];
                tail_reg[s]       <= tail_next[s];
                count_reg[s]      <= count_next[s];
                vehicles_reg[s]   <= vehicles_next[s];
                wait_total_reg[s] <= wait_total_next[s];
                max_wait_reg[s]   <= max_wait_next[s];
                clearance_reg[s]  <= clearance_next[s];
            end
        end
    end

    // prefetch the next head entry; forward a write to the same slot
    always_ff @(posedge clk)
    begin
        if (wr_en[0])
        begin
            left_times_mem[tail_reg[0]] <= stamp;
        end
        rd_data_reg[0]     <= left_times_mem[head_next[0]];
        bypass_data_reg[0] <= stamp;
        bypass_sel_reg[0]  <= wr_en[0] && (tail_reg[0] == head_next[0]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en[1])
        begin
            right_times_mem[tail_reg[1]] <= stamp;
        end
        rd_data_reg[1]     <= right_times_mem[head_next[1]];
        bypass_data_reg[1] <= stamp;
        bypass_sel_reg[1]  <= wr_en[1] && (tail_reg[1] == head_next[1]);
    end

    `TLQ_ASSERT_IMPL(a_left_count_bound, clk, rst_n, 1'b1, count_reg[0] <= DEPTH_CNT, "left queue count over depth")
    `TLQ_ASSERT_IMPL(a_right_count_bound, clk, rst_n, 1'b1, count_reg[1] <= DEPTH_CNT, "right queue count over depth")
    `TLQ_ASSERT_NEXT(a_period_hold, clk, rst_n, !step, period_reg == $past(period_reg), "period moved without a step")
    `TLQ_ASSERT_IMPL(a_idle_no_serve, clk, rst_n, fire && idle, res.served_side == tlq_pkg::SERVED_NONE && res.served_wait == '0, "car served in idle drain period")
    `TLQ_ASSERT_NEXT(a_left_pop_empty, clk, rst_n, step && pop[0] && (count_reg[0] == '0), count_reg[0] == '0, "same-period left serve left a car queued")
    `TLQ_ASSERT_NEXT(a_right_pop_empty, clk, rst_n, step && pop[1] && (count_reg[1] == '0), count_reg[1] == '0, "same-period right serve left a car queued")

endmodule

### hdl/tlq_result_queue.sv
`timescale 1ns / 1ps
module tlq_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  tlq_pkg::result_t res,
    output logic             res_full,
    output logic             empty,
    input  logic             pop,
    output tlq_pkg::result_t result
);

    tlq_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign result   = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

### hdl/two_way_light_queue_server_core.sv
`timescale 1ns / 1ps
// Path: a request accepted into the input queue is taken by the service engine, which
// writes its result into the result queue, from which it drives the result ports.
// Throughput: one request per cycle while the result queue has room, set by the engine
// step with its prefetched queue-head memory read.
// Reset: rst_n is asynchronous, active low; lights left green, counters and queues empty,
// both green periods 10. No clearing pass: the arrival-time memories need none.
module two_way_light_queue_server_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  tlq_pkg::cfg_addr_t          cfg_addr,
    input  logic [tlq_pkg::PHASE_W-1:0] cfg_data,
    input  logic                        push,
    output logic                        full,
    input  tlq_pkg::in_item_t           item,
    output logic                        empty,
    input  logic                        pop,
    output tlq_pkg::result_t            result
);

    tlq_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_take;
    logic             res_full;
    logic             res_push;
    tlq_pkg::result_t res;

    tlq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tlq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    tlq_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
